@@ hdl/efd_pkg.sv @@
// ----------------------------------------------------------------------------
// efd_pkg
// Shared constants and types for the escaped frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int LEN_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [7:0] ESCAPE_RESET = 8'h48;
    localparam logic [7:0] START_RESET  = 8'h10;

    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
    } drain_req_t;

endpackage

`default_nettype wire

@@ hdl/efd_ram.sv @@
// ----------------------------------------------------------------------------
// efd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/efd_parser.sv @@
// ----------------------------------------------------------------------------
// efd_parser
// Escape/start parser: tracks phase, writes payload bytes into the buffer
// RAM and hands a drain request to the drain unit on frame close.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_parser
    import efd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int AW        = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [7:0]            byte_in,
    output logic                       wr_en,
    output logic      [AW-1:0]         wr_addr,
    output logic      [7:0]            wr_data,
    output drain_req_t                 req
);

    typedef enum logic [1:0] {
        HUNT,
        HUNT_ESC,
        FRAME,
        FRAME_ESC
    } phase_t;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       esc_reg, start_reg;
    logic             accept, is_esc, is_start, do_store;

    assign accept   = in_valid && in_ready;
    assign is_esc   = (byte_in == esc_reg);
    assign is_start = (byte_in == start_reg);
    assign wr_addr  = cnt_reg[AW-1:0];
    assign wr_data  = byte_in;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        do_store   = 1'b0;
        wr_en      = 1'b0;
        req        = '0;
        if (accept)
        begin
            case (phase_reg)
                HUNT:
                begin
                    if (is_esc)
                    begin
                        phase_next = HUNT_ESC;
                    end
                end
                HUNT_ESC:
                begin
                    if (is_start)
                    begin
                        cnt_next   = '0;
                        phase_next = FRAME;
                    end
                    else
                    begin
                        phase_next = HUNT;
                    end
                end
                FRAME:
                begin
                    if (is_esc)
                    begin
                        phase_next = FRAME_ESC;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                FRAME_ESC:
                begin
                    if (is_start)
                    begin
                        req.valid  = (cnt_reg != '0);
                        req.len    = cnt_reg;
                        cnt_next   = '0;
                        phase_next = HUNT;
                    end
                    else if (is_esc)
                    begin
                        do_store = 1'b1;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        phase_next = HUNT;
                    end
                end
                default:
                begin
                    phase_next = HUNT;
                end
            endcase
            if (do_store)
            begin
                if (cnt_reg >= MAX_LEN)
                begin
                    cnt_next   = '0;
                    phase_next = HUNT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    cnt_next   = cnt_reg + LEN_W'(1);
                    phase_next = FRAME;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HUNT;
            cnt_reg   <= '0;
            esc_reg   <= ESCAPE_RESET;
            start_reg <= START_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ESCAPE: esc_reg   <= cfg_data;
                    REG_START:  start_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cnt_reg < MAX_LEN))
        else $error("payload write beyond buffer");

    a_req_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> (req.len != '0 && req.len <= MAX_LEN))
        else $error("drain request with bad length");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_LEN)
        else $error("payload count overflow");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |=> (cnt_reg == '0 && phase_reg == HUNT))
        else $error("frame close did not reset parser");

endmodule

`default_nettype wire

@@ hdl/efd_drain.sv @@
// ----------------------------------------------------------------------------
// efd_drain
// Frame drain: reads the buffer RAM in order and feeds a two-entry
// output queue; marks the final byte of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_drain
    import efd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int AW        = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire drain_req_t       req,
    output logic                  busy,
    output logic                  rd_en,
    output logic      [AW-1:0]    rd_addr,
    input  wire logic [7:0]       rd_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [7:0]       data_out,
    output logic                  frame_last
);

    logic             busy_reg, busy_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] addr_reg, addr_next;
    logic             pend_reg, pend_last_reg;
    logic [1:0]       occ_reg, occ_next, occ_after;
    logic [7:0]       data0_reg, data0_next, data1_reg, data1_next;
    logic             last0_reg, last0_next, last1_reg, last1_next;
    logic             pop, space, issue, is_last;

    assign out_valid  = (occ_reg != 2'd0);
    assign data_out   = data0_reg;
    assign frame_last = last0_reg;
    assign busy       = busy_reg;

    assign pop       = out_valid && out_ready;
    assign occ_after = occ_reg - {1'b0, pop};
    // room for a read issued now must hold even if nothing pops next cycle
    assign space     = ((occ_after + {1'b0, pend_reg}) < 2'd2);
    assign issue     = busy_reg && space;
    assign is_last   = (addr_reg == (len_reg - LEN_W'(1)));
    assign rd_en     = issue;
    assign rd_addr   = addr_reg[AW-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        len_next  = len_reg;
        addr_next = addr_reg;
        if (req.valid)
        begin
            busy_next = 1'b1;
            len_next  = req.len;
            addr_next = '0;
        end
        else if (issue)
        begin
            addr_next = addr_reg + LEN_W'(1);
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        data0_next = data0_reg;
        data1_next = data1_reg;
        last0_next = last0_reg;
        last1_next = last1_reg;
        if (pop)
        begin
            data0_next = data1_reg;
            last0_next = last1_reg;
        end
        if (pend_reg)
        begin
            if (occ_after == 2'd0)
            begin
                data0_next = rd_data;
                last0_next = pend_last_reg;
            end
            else
            begin
                data1_next = rd_data;
                last1_next = pend_last_reg;
            end
        end
        occ_next = occ_after + {1'b0, pend_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            len_reg       <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            occ_reg       <= 2'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            len_reg       <= len_next;
            addr_reg      <= addr_next;
            pend_reg      <= issue;
            pend_last_reg <= issue && is_last;
            occ_reg       <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
        last0_reg <= last0_next;
        last1_reg <= last1_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != 2'd3)
        else $error("output queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (occ_reg != 2'd2 || pop))
        else $error("read data arrives with no queue room");

    a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> !busy_reg)
        else $error("drain request while draining");

    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |=> busy_reg)
        else $error("drain did not start");

endmodule

`default_nettype wire

@@ hdl/escaped_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// escaped_frame_deframer_unit
// Byte-stuffed frame recovery: escape+start delimits frames, doubled escape
// is a literal escape byte; completed payloads come out as a flagged run.
// ----------------------------------------------------------------------------
//
//  channel  signals                                     direction
//  -------  ------------------------------------------  ---------
//  input    in_valid, in_ready, byte_in                 in
//  output   out_valid, out_ready, data_out, frame_last  out
//  config   cfg_we, cfg_index, cfg_data                 in
//
//  One input byte per cycle while parsing.
//  A frame close of N bytes drains the buffer RAM at up to one byte per cycle;
//  in_ready is low after the close while the RAM read
//  port walks the buffer, and longer while out_ready holds the queue full.
//  The first byte of a run is offered once it is read into the output queue.
//  Reset: phase hunting, count zero, codes 0x48 / 0x10; buffer not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_deframer_unit
    import efd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            byte_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [7:0]            data_out,
    output logic                       frame_last
);

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

    drain_req_t       req;
    logic             busy;
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [7:0]       wr_data, rd_data;

    assign in_ready = !busy;

    efd_parser #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .req       (req)
    );

    efd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    efd_drain #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_drain (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .busy       (busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire

@@ verif/escaped_frame_checker.sv @@
// ----------------------------------------------------------------------------
// escaped_frame_checker
// Tracks the deframer's register writes and accepted input bytes with its own
// parser, queues the payload items each frame close should release, and
// compares every accepted output item against the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module escaped_frame_checker
    import efd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            byte_in,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [7:0]            data_out,
    input  logic                  frame_last,
    output int                    fail_count,
    output int                    pending
);

    typedef enum logic [1:0] {
        HUNT,
        HUNT_ESC,
        IN_FRAME,
        FRAME_ESC
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } payload_item_t;

    parse_phase_t  parse_phase;
    logic [7:0]    esc_code;
    logic [7:0]    sof_code;
    logic [7:0]    frame_bytes[$];
    payload_item_t expected_items[$];
    int            mismatches;

    task automatic drop_frame();
        frame_bytes.delete();
        parse_phase = HUNT;
    endtask

    task automatic keep_byte(input logic [7:0] value);
        if (frame_bytes.size() >= MAX_FRAME) begin
            drop_frame();
        end
        else begin
            frame_bytes.push_back(value);
            parse_phase = IN_FRAME;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        payload_item_t head;
        if (!rst_n)
        begin
            esc_code    = ESCAPE_RESET;
            sof_code    = START_RESET;
            parse_phase = HUNT;
            mismatches  = 0;
            frame_bytes.delete();
            expected_items.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_items.size() == 0)
                begin
                    $error("data_out: expected no item, actual %02h (frame_last %0b)",
                           data_out, frame_last);
                    mismatches++;
                end
                else
                begin
                    head = expected_items.pop_front();
                    if (data_out !== head.data)
                    begin
                        $error("data_out mismatch: expected %02h, actual %02h",
                               head.data, data_out);
                        mismatches++;
                    end
                    if (frame_last !== head.last)
                    begin
                        $error("frame_last mismatch: expected %0b, actual %0b",
                               head.last, frame_last);
                        mismatches++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ESCAPE: esc_code = cfg_data;
                    REG_START:  sof_code = cfg_data;
                    default:    ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                case (parse_phase)
                    HUNT:
                    begin
                        if (byte_in == esc_code)
                            parse_phase = HUNT_ESC;
                    end
                    HUNT_ESC:
                    begin
                        if (byte_in == sof_code)
                        begin
                            frame_bytes.delete();
                            parse_phase = IN_FRAME;
                        end
                        else
                            parse_phase = HUNT;
                    end
                    IN_FRAME:
                    begin
                        if (byte_in == esc_code)
                            parse_phase = FRAME_ESC;
                        else
                            keep_byte(byte_in);
                    end
                    default:
                    begin
                        // start wins over escape when both codes match
                        if (byte_in == sof_code)
                        begin
                            foreach (frame_bytes[i])
                                expected_items.push_back(
                                    '{data: frame_bytes[i],
                                      last: (i == frame_bytes.size() - 1)});
                            drop_frame();
                        end
                        else if (byte_in == esc_code)
                            keep_byte(byte_in);
                        else
                            drop_frame();
                    end
                endcase
            end

            fail_count <= mismatches;
            pending    <= expected_items.size();
        end
    end

endmodule

@@ verif/tb_escaped_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_escaped_frame_deframer_unit
// Drives byte streams into the deframer under several escape/start code
// settings: well-formed frames with random payloads, empty, full-size and
// oversized frames, escape errors and noise, with random idle on both sides
// and one long output stall. The checker judges every output item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_escaped_frame_deframer_unit;

    import efd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 100;
    localparam int PHASE_ITEMS    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            byte_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            data_out;
    logic                  frame_last;

    int fail_count;
    int pending;

    logic [7:0] esc_code;
    logic [7:0] sof_code;
    logic       steady;
    logic       hold_request;
    int         items_sent;
    int         quiet_cycles;
    logic [7:0] opening_seq [26];

    escaped_frame_deframer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out),
        .frame_last (frame_last)
    );

    escaped_frame_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out),
        .frame_last (frame_last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: mostly short stalls, some long ones, one very long hold-off
    initial
    begin
        logic level;
        int   run_len;
        int   pick;
        logic hold_done;
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                level     = 1'b0;
                run_len   = HOLD_CYCLES;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    level   = 1'b1;
                    run_len = $urandom_range(1, 8);
                end
                else if (pick < 65)
                begin
                    level   = 1'b1;
                    run_len = $urandom_range(40, 120);
                end
                else if (pick < 95)
                begin
                    level   = 1'b0;
                    run_len = $urandom_range(1, 3);
                end
                else
                begin
                    level   = 1'b0;
                    run_len = $urandom_range(15, 50);
                end
            end
            repeat (run_len)
            begin
                @(negedge clk);
                out_ready <= level;
            end
        end
    end

    function automatic int idle_gap();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] other_byte();
        logic [7:0] value;
        do
            value = 8'($urandom_range(0, 255));
        while (value == esc_code || value == sof_code);
        return value;
    endfunction

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return esc_code;
            1:       return sof_code;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = idle_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        byte_in  <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_delim();
        send_byte(esc_code);
        send_byte(sof_code);
    endtask

    task automatic send_frame(input int len);
        logic [7:0] value;
        send_delim();
        repeat (len)
        begin
            value = payload_byte();
            send_byte(value);
            if (value == esc_code)
                send_byte(value);
        end
        send_delim();
    endtask

    task automatic send_oversized(input int len);
        send_delim();
        repeat (len)
            send_byte(other_byte());
        send_delim();
    endtask

    task automatic run_traffic(input int budget);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < budget)
        begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                       : $urandom_range(1, 14));
            else if (pick < 77)
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            else if (pick < 85)
            begin
                send_byte(esc_code);
                send_byte(other_byte());
            end
            else if (pick < 95)
            begin
                send_delim();
                repeat ($urandom_range(0, 6))
                    send_byte(other_byte());
                send_byte(esc_code);
                send_byte(other_byte());
            end
            else if (pick < 97)
                send_frame(MAX_FRAME_DEF);
            else
                send_oversized(MAX_FRAME_DEF + $urandom_range(1, 3));
        end
        steady = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (index)
            REG_ESCAPE: esc_code = value;
            REG_START:  sof_code = value;
            default:    ;
        endcase
    endtask

    initial
    begin
        logic [7:0] esc_list [5];
        logic [7:0] sof_list [5];
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        byte_in      = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        quiet_cycles = 0;
        esc_code     = ESCAPE_RESET;
        sof_code     = START_RESET;

        // literal escape, byte extremes, empty frame, escape errors
        opening_seq = '{ESCAPE_RESET, START_RESET, 8'h00, 8'hFF, ESCAPE_RESET,
                        ESCAPE_RESET, START_RESET, ESCAPE_RESET, START_RESET,
                        ESCAPE_RESET, START_RESET, ESCAPE_RESET, START_RESET,
                        ESCAPE_RESET, ESCAPE_RESET, START_RESET,
                        ESCAPE_RESET, START_RESET, 8'h55, ESCAPE_RESET, 8'h77,
                        ESCAPE_RESET, START_RESET, 8'hAA, ESCAPE_RESET, START_RESET};

        esc_list = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00};
        sof_list = '{8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00};
        esc_list[3] = 8'($urandom_range(0, 255));
        sof_list[3] = 8'($urandom_range(0, 255));
        esc_list[4] = ESCAPE_RESET;
        sof_list[4] = START_RESET;

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening_seq[i])
            send_byte(opening_seq[i]);

        // full buffer while the receiver holds off, then one too many
        hold_request = 1'b1;
        send_frame(MAX_FRAME_DEF);
        send_oversized(MAX_FRAME_DEF + 1);
        run_traffic(PHASE_ITEMS / 2);

        foreach (esc_list[i])
        begin
            wait_idle();
            if (i == 3)
            begin
                write_reg(REG_SPARE_A, 8'($urandom_range(0, 255)));
                write_reg(REG_SPARE_B, 8'($urandom_range(0, 255)));
            end
            write_reg(REG_ESCAPE, esc_list[i]);
            write_reg(REG_START, sof_list[i]);
            run_traffic(PHASE_ITEMS);
        end

        wait_idle();
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
